/* rtl/core/chfx_pkg.sv */
// shared types, constants and tables for the compass heading block
`default_nettype none

package chfx_pkg;

   localparam int HEADING_FRAC_BITS = 6;
   localparam int HEADING_W = 15;
   localparam int AXIS_W = 16;
   localparam int CORR_W = AXIS_W + 1;

   localparam int CORDIC_STEPS = 30;
   localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
   localparam int CORDIC_W = 40;
   localparam int PRESCALE = 20;
   localparam int ANGLE_W = 30;
   localparam int ZACC_W = ANGLE_W + 1;

   localparam int DEG_W = 34;
   localparam logic [ANGLE_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;
   localparam logic [DEG_W-1:0] DEG90_Q24 = 34'(90) << 24;
   localparam logic [DEG_W-1:0] DEG180_Q24 = 34'(180) << 24;
   localparam logic [DEG_W-1:0] DEG360_Q24 = 34'(360) << 24;

   localparam logic signed [AXIS_W-1:0] X_OFFSET_RESET = 16'sd84;
   localparam logic signed [AXIS_W-1:0] Y_OFFSET_RESET = 16'sd169;

   localparam logic REG_X_OFFSET = 1'b0;
   localparam logic REG_Y_OFFSET = 1'b1;

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic swap;
      logic zero_b;
   } quad_type;

   // atan(2^-i) in radians scaled by 2^30
   function automatic logic [ANGLE_W-1:0] atan_rom(input logic [STEP_W-1:0] idx);
      logic [ANGLE_W-1:0] val;
      val = '0;
      unique case (idx)
         5'd1: val = 30'd497837829;
         5'd2: val = 30'd263043837;
         5'd3: val = 30'd133525159;
         5'd4: val = 30'd67021687;
         5'd5: val = 30'd33543516;
         5'd6: val = 30'd16775851;
         5'd7: val = 30'd8388437;
         5'd8: val = 30'd4194283;
         5'd9: val = 30'd2097149;
         default: begin
            if (idx >= 5'd10 && idx <= 5'(CORDIC_STEPS)) begin
               val = 30'(1) << (5'(ANGLE_W) - idx);
            end
         end
      endcase
      return val;
   endfunction

   // shift of the magnitude, sign put back afterwards
   function automatic logic signed [CORDIC_W-1:0] sm_shr(
      input logic signed [CORDIC_W-1:0] v,
      input logic [STEP_W-1:0] s
   );
      logic [CORDIC_W-1:0] mag;
      mag = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
      mag = mag >> s;
      return v[CORDIC_W-1] ? $signed(-mag) : $signed(mag);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/chfx_cordic.sv */
// iterative vectoring cordic giving atan(b/a) for 0 <= b <= a
`default_nettype none

module chfx_cordic (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [chfx_pkg::CORR_W-1:0]       a,
   input  wire logic [chfx_pkg::CORR_W-1:0]       b,
   output logic                                   done,
   output logic [chfx_pkg::ANGLE_W-1:0]           angle
);

   localparam int CW = chfx_pkg::CORDIC_W;
   localparam int ZW = chfx_pkg::ZACC_W;
   localparam int SW = chfx_pkg::STEP_W;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SW-1:0]        step_ff, step_in;
   logic signed [CW-1:0] x_ff, x_in;
   logic signed [CW-1:0] y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;

   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   logic signed [ZW-1:0] atan_val;
   logic                 y_pos;

   assign dx       = chfx_pkg::sm_shr(y_ff, step_ff);
   assign dy       = chfx_pkg::sm_shr(x_ff, step_ff);
   assign atan_val = $signed(ZW'(chfx_pkg::atan_rom(step_ff)));
   assign y_pos    = !y_ff[CW-1] && (y_ff != '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = SW'(1);
         x_in    = $signed(CW'(a) << chfx_pkg::PRESCALE);
         y_in    = $signed(CW'(b) << chfx_pkg::PRESCALE);
         z_in    = '0;
      end else if (busy_ff) begin
         if (y_pos) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_val;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_val;
         end
         step_in = step_ff + SW'(1);
         if (step_ff == SW'(chfx_pkg::CORDIC_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done  = done_ff;
   assign angle = z_ff[ZW-1] ? '0 : z_ff[chfx_pkg::ANGLE_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/chfx_conv.sv */
// radians to degrees with a split multiply, quadrant fold and final rounding
`default_nettype none

module chfx_conv #(
   parameter int FRAC_BITS = chfx_pkg::HEADING_FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [chfx_pkg::ANGLE_W-1:0]      angle,
   input  wire chfx_pkg::quad_type                quad,
   output logic                                   done,
   output logic [chfx_pkg::HEADING_W-1:0]         heading
);

   localparam int AW = chfx_pkg::ANGLE_W;
   localparam int HALF = AW / 2;
   localparam int PW = HALF + AW;
   localparam int ACC_W = 2 * AW;
   localparam int DW = chfx_pkg::DEG_W;
   localparam int SHIFT = 24 - FRAC_BITS;
   localparam logic [DW-1:0] RND = DW'(1) << (23 - FRAC_BITS);
   localparam logic [DW-1:0] FULL = DW'(360) << FRAC_BITS;

   localparam logic [1:0] PH_LO  = 2'd0;
   localparam logic [1:0] PH_HI  = 2'd1;
   localparam logic [1:0] PH_ANG = 2'd2;
   localparam logic [1:0] PH_RND = 2'd3;

   logic                 busy_ff;
   logic                 done_ff;
   logic [1:0]           phase_ff;
   logic [ACC_W-1:0]     acc_ff;
   logic [DW-1:0]        d_ff;
   logic [chfx_pkg::HEADING_W-1:0] heading_ff;

   logic [HALF-1:0]      mop;
   logic [PW-1:0]        prod;
   logic [AW-1:0]        oct;
   logic [DW-1:0]        t;
   logic [DW-1:0]        d_in;
   logic [DW-1:0]        h_full;
   logic [DW-1:0]        h_wrap;

   assign mop  = (phase_ff == PH_LO) ? angle[HALF-1:0] : angle[AW-1:HALF];
   assign prod = PW'(mop) * PW'(chfx_pkg::DEG_PER_RAD_Q24);

   always_comb begin
      oct = quad.zero_b ? '0 : AW'((acc_ff + (ACC_W'(1) << 29)) >> 30);
      t   = quad.swap ? chfx_pkg::DEG90_Q24 - DW'(oct) : DW'(oct);
      priority if (!quad.x_neg && !quad.y_neg) begin
         d_in = t;
      end else if (quad.x_neg && !quad.y_neg) begin
         d_in = chfx_pkg::DEG180_Q24 - t;
      end else if (quad.x_neg) begin
         d_in = chfx_pkg::DEG180_Q24 + t;
      end else begin
         d_in = chfx_pkg::DEG360_Q24 - t;
      end
      h_full = (d_ff + RND) >> SHIFT;
      h_wrap = (h_full >= FULL) ? h_full - FULL : h_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_LO;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= PH_LO;
         end else if (busy_ff) begin
            phase_ff <= phase_ff + 2'd1;
            if (phase_ff == PH_RND) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         unique case (phase_ff)
            PH_LO:  acc_ff <= ACC_W'(prod);
            PH_HI:  acc_ff <= acc_ff + (ACC_W'(prod) << HALF);
            PH_ANG: d_ff <= d_in;
            PH_RND: heading_ff <= h_wrap[chfx_pkg::HEADING_W-1:0];
            default: ;
         endcase
      end
   end

   assign done    = done_ff;
   assign heading = heading_ff;

endmodule

`default_nettype wire

/* rtl/core/compass_heading_from_xy.sv */
// Compass heading from magnetometer X/Y bytes. An item with data_ready set forms signed
// X, Y and Z, adds the X and Y offsets at 17 bits and returns atan2(y, x) in degrees
// (fraction bits set by HEADING_FRAC_BITS, wrapped into [0, 360)) plus the corrected axes.
// Such an item passes from acceptance through a setup state, 30 steps of the cordic
// shift-add unit and a hand-over, the split degree conversion (low and high multiply,
// angle fold, rounding), the load of the output register and a return to idle, where the
// next item can be accepted. An item with data_ready clear produces no result and leaves
// the block idle. With one corrected axis zero the cordic is skipped; with both zero the
// previous heading is repeated.
// The input is not ready while an item is being worked on; a finished result
// waits in the output register while the next item is taken, and a result that still
// waits when the next one is finished stalls the block until it is taken.
`default_nettype none

module compass_heading_from_xy #(
   parameter int HEADING_FRAC_BITS = chfx_pkg::HEADING_FRAC_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_data_ready,
   input  wire logic [7:0]                           req_x_high,
   input  wire logic [7:0]                           req_x_low,
   input  wire logic [7:0]                           req_z_high,
   input  wire logic [7:0]                           req_z_low,
   input  wire logic [7:0]                           req_y_high,
   input  wire logic [7:0]                           req_y_low,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [chfx_pkg::HEADING_W-1:0]            rsp_heading,
   output logic signed [chfx_pkg::CORR_W-1:0]        rsp_x_corrected,
   output logic signed [chfx_pkg::CORR_W-1:0]        rsp_y_corrected,
   output logic signed [chfx_pkg::AXIS_W-1:0]        rsp_z_value,

   input  wire logic                                 csr_we,
   input  wire logic                                 csr_index,
   input  wire logic [chfx_pkg::AXIS_W-1:0]          csr_wdata
);

   localparam int AXW = chfx_pkg::AXIS_W;
   localparam int CRW = chfx_pkg::CORR_W;
   localparam int HW  = chfx_pkg::HEADING_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PREP  = 5'b00010,
      ST_ANGLE = 5'b00100,
      ST_CONV  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic signed [AXW-1:0] x_offset_ff;
   logic signed [AXW-1:0] y_offset_ff;
   logic [HW-1:0]         last_heading_ff;
   logic                  rsp_valid_ff;

   logic signed [CRW-1:0] xc_ff, xc_in;
   logic signed [CRW-1:0] yc_ff, yc_in;
   logic signed [AXW-1:0] zs_ff;
   chfx_pkg::quad_type    quad_ff, quad_in;

   logic [HW-1:0]         rsp_heading_ff;
   logic signed [CRW-1:0] rsp_x_ff;
   logic signed [CRW-1:0] rsp_y_ff;
   logic signed [AXW-1:0] rsp_z_ff;

   logic signed [AXW-1:0] xs;
   logic signed [AXW-1:0] ys;
   logic [CRW-1:0]        ax;
   logic [CRW-1:0]        ay;
   logic [CRW-1:0]        op_a;
   logic [CRW-1:0]        op_b;
   logic                  both_zero;
   logic                  req_take;
   logic                  out_free;
   logic                  cordic_start;
   logic                  cordic_done;
   logic [chfx_pkg::ANGLE_W-1:0] cordic_angle;
   logic                  conv_start;
   logic                  conv_done;
   logic [HW-1:0]         conv_heading;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready && req_data_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign xs    = $signed({req_x_high, req_x_low});
   assign ys    = $signed({req_y_high, req_y_low});
   assign xc_in = $signed({xs[AXW-1], xs}) + $signed({x_offset_ff[AXW-1], x_offset_ff});
   assign yc_in = $signed({ys[AXW-1], ys}) + $signed({y_offset_ff[AXW-1], y_offset_ff});

   // magnitudes, larger one goes to the cordic x input
   always_comb begin
      ax = xc_ff[CRW-1] ? CRW'(-xc_ff) : CRW'(xc_ff);
      ay = yc_ff[CRW-1] ? CRW'(-yc_ff) : CRW'(yc_ff);
      quad_in.x_neg = xc_ff[CRW-1];
      quad_in.y_neg = yc_ff[CRW-1];
      quad_in.swap  = (ay > ax);
      op_a = quad_in.swap ? ay : ax;
      op_b = quad_in.swap ? ax : ay;
      quad_in.zero_b = (op_b == '0);
      both_zero = (xc_ff == '0) && (yc_ff == '0);
   end

   always_comb begin
      state_in     = state_ff;
      cordic_start = 1'b0;
      conv_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            priority if (both_zero) begin
               state_in = ST_OUT;
            end else if (quad_in.zero_b) begin
               conv_start = 1'b1;
               state_in   = ST_CONV;
            end else begin
               cordic_start = 1'b1;
               state_in     = ST_ANGLE;
            end
         end
         ST_ANGLE: begin
            if (cordic_done) begin
               conv_start = 1'b1;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         x_offset_ff     <= chfx_pkg::X_OFFSET_RESET;
         y_offset_ff     <= chfx_pkg::Y_OFFSET_RESET;
         last_heading_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               chfx_pkg::REG_X_OFFSET: x_offset_ff <= $signed(csr_wdata);
               chfx_pkg::REG_Y_OFFSET: y_offset_ff <= $signed(csr_wdata);
               default: ;
            endcase
         end
         if (state_ff == ST_CONV && conv_done) begin
            last_heading_ff <= conv_heading;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         xc_ff <= xc_in;
         yc_ff <= yc_in;
         zs_ff <= $signed({req_z_high, req_z_low});
      end
      if (state_ff == ST_PREP) begin
         quad_ff <= quad_in;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_heading_ff <= last_heading_ff;
         rsp_x_ff       <= xc_ff;
         rsp_y_ff       <= yc_ff;
         rsp_z_ff       <= zs_ff;
      end
   end

   chfx_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .a     (op_a),
      .b     (op_b),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   chfx_conv #(
      .FRAC_BITS (HEADING_FRAC_BITS)
   ) u_conv (
      .clock   (clock),
      .reset   (reset),
      .start   (conv_start),
      .angle   (cordic_angle),
      .quad    ((state_ff == ST_PREP) ? quad_in : quad_ff),
      .done    (conv_done),
      .heading (conv_heading)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_heading     = rsp_heading_ff;
   assign rsp_x_corrected = rsp_x_ff;
   assign rsp_y_corrected = rsp_y_ff;
   assign rsp_z_value     = rsp_z_ff;

endmodule

`default_nettype wire

/* tb/tb_compass_heading_from_xy.sv */
// self-checking testbench for compass_heading_from_xy: random handshakes, cordic predictor
`default_nettype none

module tb_compass_heading_from_xy;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic       data_ready;
      logic [7:0] x_high;
      logic [7:0] x_low;
      logic [7:0] z_high;
      logic [7:0] z_low;
      logic [7:0] y_high;
      logic [7:0] y_low;
   } mag_sample_type;

   typedef struct packed {
      logic [chfx_pkg::HEADING_W-1:0]      heading;
      logic signed [chfx_pkg::CORR_W-1:0]  x_corrected;
      logic signed [chfx_pkg::CORR_W-1:0]  y_corrected;
      logic signed [chfx_pkg::AXIS_W-1:0]  z_value;
   } heading_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_data_ready = 1'b0;
   logic [7:0]  req_x_high = '0;
   logic [7:0]  req_x_low = '0;
   logic [7:0]  req_z_high = '0;
   logic [7:0]  req_z_low = '0;
   logic [7:0]  req_y_high = '0;
   logic [7:0]  req_y_low = '0;

   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [chfx_pkg::HEADING_W-1:0]      rsp_heading;
   logic signed [chfx_pkg::CORR_W-1:0]  rsp_x_corrected;
   logic signed [chfx_pkg::CORR_W-1:0]  rsp_y_corrected;
   logic signed [chfx_pkg::AXIS_W-1:0]  rsp_z_value;

   logic                          csr_we = 1'b0;
   logic                          csr_index = chfx_pkg::REG_X_OFFSET;
   logic [chfx_pkg::AXIS_W-1:0]   csr_wdata = '0;

   // predictor state
   longint                              atan_q30 [1:chfx_pkg::CORDIC_STEPS];
   logic signed [chfx_pkg::AXIS_W-1:0]  x_offset_q = chfx_pkg::X_OFFSET_RESET;
   logic signed [chfx_pkg::AXIS_W-1:0]  y_offset_q = chfx_pkg::Y_OFFSET_RESET;
   logic [chfx_pkg::HEADING_W-1:0]      last_heading_q = '0;

   mag_sample_type      samples_to_send [$];
   mag_sample_type      cur_sample;
   heading_result_type  due_results [$];

   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          samples_queued = 0;
   int          samples_sent = 0;
   int          results_seen = 0;
   int          mismatches = 0;
   int          offset_settings = 1;
   int unsigned cycle_count = 0;

   compass_heading_from_xy dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_ready  (req_data_ready),
      .req_x_high      (req_x_high),
      .req_x_low       (req_x_low),
      .req_z_high      (req_z_high),
      .req_z_low       (req_z_low),
      .req_y_high      (req_y_high),
      .req_y_low       (req_y_low),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_heading     (rsp_heading),
      .rsp_x_corrected (rsp_x_corrected),
      .rsp_y_corrected (rsp_y_corrected),
      .rsp_z_value     (rsp_z_value),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   // atan(b/a) in degrees scaled by 2^24, for 0 <= b <= a and a > 0
   function automatic longint unsigned octant_angle_q24(input longint b, input longint a);
      longint cx, cy, cz, dx, dy;
      if (b == 0) return 0;
      cx = a << chfx_pkg::PRESCALE;
      cy = b << chfx_pkg::PRESCALE;
      cz = 0;
      for (int i = 1; i <= chfx_pkg::CORDIC_STEPS; i++) begin
         dx = (cy < 0) ? -((-cy) >>> i) : (cy >>> i);
         dy = (cx < 0) ? -((-cx) >>> i) : (cx >>> i);
         if (cy > 0) begin
            cx += dx;
            cy -= dy;
            cz += atan_q30[i];
         end else begin
            cx -= dx;
            cy += dy;
            cz -= atan_q30[i];
         end
      end
      if (cz < 0) cz = 0;
      return (64'(cz) * 64'(chfx_pkg::DEG_PER_RAD_Q24) + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [chfx_pkg::HEADING_W-1:0] heading_for(input longint x,
                                                                  input longint y);
      longint ax, ay;
      longint unsigned t, d, h, full;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ay <= ax) t = octant_angle_q24(ay, ax);
      else t = 64'(chfx_pkg::DEG90_Q24) - octant_angle_q24(ax, ay);
      if (x >= 0 && y >= 0) d = t;
      else if (x < 0 && y >= 0) d = 64'(chfx_pkg::DEG180_Q24) - t;
      else if (x < 0) d = 64'(chfx_pkg::DEG180_Q24) + t;
      else d = 64'(chfx_pkg::DEG360_Q24) - t;
      h = (d + (64'd1 << (23 - chfx_pkg::HEADING_FRAC_BITS)))
          >> (24 - chfx_pkg::HEADING_FRAC_BITS);
      full = 64'd360 << chfx_pkg::HEADING_FRAC_BITS;
      if (h >= full) h -= full;
      return chfx_pkg::HEADING_W'(h);
   endfunction

   // only called for items with new data
   function automatic heading_result_type predict_heading_result(input mag_sample_type s);
      heading_result_type r;
      longint xc, yc;
      xc = longint'($signed({s.x_high, s.x_low})) + longint'(x_offset_q);
      yc = longint'($signed({s.y_high, s.y_low})) + longint'(y_offset_q);
      if (xc != 0 || yc != 0) last_heading_q = heading_for(xc, yc);
      r.heading = last_heading_q;
      r.x_corrected = chfx_pkg::CORR_W'(xc);
      r.y_corrected = chfx_pkg::CORR_W'(yc);
      r.z_value = $signed({s.z_high, s.z_low});
      return r;
   endfunction

   function automatic mag_sample_type make_sample(input bit ready, input int xv, input int zv,
                                                  input int yv);
      mag_sample_type s;
      s.data_ready = ready;
      s.x_high = 8'(xv >> 8);
      s.x_low = 8'(xv);
      s.z_high = 8'(zv >> 8);
      s.z_low = 8'(zv);
      s.y_high = 8'(yv >> 8);
      s.y_low = 8'(yv);
      return s;
   endfunction

   function automatic int random_axis(input logic signed [chfx_pkg::AXIS_W-1:0] off);
      case ($urandom_range(9))
         0: return -int'(off) + int'($urandom_range(8)) - 4;
         1: return $urandom_range(1) ? 32767 : -32768;
         2: return int'($urandom_range(32)) - 16;
         3: return -int'(off);
         default: return int'($urandom_range(65535));
      endcase
   endfunction

   function automatic mag_sample_type random_sample();
      int xv, yv, zv, sel;
      bit ready;
      ready = ($urandom_range(99) < 85);
      sel = $urandom_range(19);
      xv = random_axis(x_offset_q);
      yv = random_axis(y_offset_q);
      zv = $urandom_range(65535);
      if (sel == 0) begin
         xv = -int'(x_offset_q);
         yv = -int'(y_offset_q);
      end else if (sel == 1) begin
         // on a diagonal
         yv = ($urandom_range(1) ? 1 : -1) * (xv + int'(x_offset_q)) - int'(y_offset_q);
      end
      return make_sample(ready, xv, zv, yv);
   endfunction

   function automatic void queue_sample(input mag_sample_type s);
      samples_to_send.push_back(s);
      samples_queued++;
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endfunction

   task automatic write_offsets(input logic signed [chfx_pkg::AXIS_W-1:0] xo,
                                input logic signed [chfx_pkg::AXIS_W-1:0] yo);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= chfx_pkg::REG_X_OFFSET;
      csr_wdata <= xo;
      x_offset_q = xo;
      @(posedge clock);
      csr_index <= chfx_pkg::REG_Y_OFFSET;
      csr_wdata <= yo;
      y_offset_q = yo;
      @(posedge clock);
      csr_we <= 1'b0;
      offset_settings++;
   endtask

   task automatic wait_for_drain();
      while (samples_sent < samples_queued || due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin : drive_req
      bit hold;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         hold = req_valid;
         if (req_valid && req_ready) begin
            samples_sent++;
            if (cur_sample.data_ready) due_results.push_back(predict_heading_result(cur_sample));
            hold = 1'b0;
         end
         if (!hold) begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               cur_sample = samples_to_send.pop_front();
               req_valid <= 1'b1;
               req_data_ready <= cur_sample.data_ready;
               req_x_high <= cur_sample.x_high;
               req_x_low <= cur_sample.x_low;
               req_z_high <= cur_sample.z_high;
               req_z_low <= cur_sample.z_low;
               req_y_high <= cur_sample.y_high;
               req_y_low <= cur_sample.y_low;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_rsp
      heading_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
               log_mismatch($sformatf("unexpected result: h=%0d x=%0d y=%0d z=%0d",
                  rsp_heading, rsp_x_corrected, rsp_y_corrected, rsp_z_value));
            end else begin
               want = due_results.pop_front();
               if (rsp_heading !== want.heading || rsp_x_corrected !== want.x_corrected ||
                   rsp_y_corrected !== want.y_corrected || rsp_z_value !== want.z_value)
                  log_mismatch($sformatf(
                     "result %0d: expected h=%0d x=%0d y=%0d z=%0d, got h=%0d x=%0d y=%0d z=%0d",
                     results_seen, want.heading, want.x_corrected, want.y_corrected,
                     want.z_value, rsp_heading, rsp_x_corrected, rsp_y_corrected,
                     rsp_z_value));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  due_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : run_test
      longint unsigned sum, term;
      int pw;
      logic signed [chfx_pkg::AXIS_W-1:0] xo, yo;

      // arctangent table from the series, radians scaled by 2^30
      for (int i = 1; i <= chfx_pkg::CORDIC_STEPS; i++) begin
         sum = 0;
         for (int k = 0; k < 40; k++) begin
            pw = (2 * k + 1) * i;
            if (pw > 60) break;
            term = (64'd1 << (60 - pw)) / (2 * k + 1);
            if (k % 2 == 1) sum -= term;
            else sum += term;
         end
         atan_q30[i] = (sum + (64'd1 << 29)) >> 30;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      tx_idle_pct = 26;
      rx_idle_pct = 53;
      // directed items at the reset offsets
      queue_sample(make_sample(1'b0, 0, 0, 0));
      queue_sample(make_sample(1'b0, -1, -1, -1));
      queue_sample(make_sample(1'b1, -84, 0, -169));
      queue_sample(make_sample(1'b1, 916, 32767, -169));
      queue_sample(make_sample(1'b1, -84, -32768, 331));
      queue_sample(make_sample(1'b1, -1084, 0, -169));
      queue_sample(make_sample(1'b1, -84, 1, -669));
      queue_sample(make_sample(1'b1, -84, -1, -169));
      queue_sample(make_sample(1'b0, 'h1234, 'h5678, 'h9abc));
      queue_sample(make_sample(1'b1, 16, 0, -69));
      queue_sample(make_sample(1'b1, -184, 0, -69));
      queue_sample(make_sample(1'b1, -184, 0, -269));
      queue_sample(make_sample(1'b1, 16, 0, -269));
      queue_sample(make_sample(1'b1, 32767, 0, 32767));
      queue_sample(make_sample(1'b1, -32768, 0, -32768));
      queue_sample(make_sample(1'b1, -32768, 0, 32767));
      queue_sample(make_sample(1'b1, 32767, 0, -32768));
      queue_sample(make_sample(1'b1, 32767, 0, -170));
      queue_sample(make_sample(1'b1, -32768, 0, -168));
      queue_sample(make_sample(1'b1, -84, 0, -170));
      queue_sample(make_sample(1'b1, -83, 0, -169));
      wait_for_drain();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin xo = -16'sd32768; yo = -16'sd32768; end
            1: begin xo = 16'sd32767; yo = 16'sd32767; end
            2: begin xo = '0; yo = '0; end
            3: begin xo = 16'sd32767; yo = -16'sd32768; end
            default: begin
               xo = chfx_pkg::AXIS_W'($urandom_range(65535));
               yo = chfx_pkg::AXIS_W'($urandom_range(65535));
            end
         endcase
         write_offsets(xo, yo);
         if (p < 2) begin
            tx_idle_pct = 26;
            rx_idle_pct = 53;
         end else if (p < 4) begin
            tx_idle_pct = 53;
            rx_idle_pct = 26;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         repeat (250) queue_sample(random_sample());
         wait_for_drain();
      end

      if (due_results.size() != 0)
         log_mismatch($sformatf("%0d expected results never arrived", due_results.size()));

      $display("sent %0d items under %0d offset settings and three idling patterns",
               samples_sent, offset_settings);
      $display("checked %0d heading results, %0d mismatches", results_seen, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/chfx_pkg.sv
rtl/core/chfx_cordic.sv
rtl/core/chfx_conv.sv
rtl/core/compass_heading_from_xy.sv
tb/tb_compass_heading_from_xy.sv
